// ===== design/gffra_pkg.sv =====
// Shared constants, result codes and controller/datapath bundles for the
// grid first-fit rectangle allocator. No dependencies.
package gffra_pkg;

    // Field widths of the channels
    localparam int TYPE_W     = 2;
    localparam int ID_IN_W    = 8;
    localparam int SIZE_W     = 5;
    localparam int POS_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Parameter defaults
    localparam int DEF_MAX_COLS = 16;
    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_ID_BITS  = 8;

    localparam logic [CFG_DATA_W-1:0] GRID_RESET = 5'd10;

    // Request types
    localparam logic [TYPE_W-1:0] REQ_PLACE  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_READ   = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd1;

    // Result staging operations
    localparam int RES_W = 3;
    localparam logic [RES_W-1:0] RES_HOLD   = 3'd0;
    localparam logic [RES_W-1:0] RES_ZERO   = 3'd1;
    localparam logic [RES_W-1:0] RES_PLACE  = 3'd2;
    localparam logic [RES_W-1:0] RES_READ   = 3'd3;
    localparam logic [RES_W-1:0] RES_REMOVE = 3'd4;

    typedef struct packed {
        logic             req_ready;
        logic             scan_start;
        logic             scan_next;
        logic             occ_set;
        logic             fill_start;
        logic             fill_run;
        logic             sweep_start;
        logic             sweep_run;
        logic             sweep_sel;
        logic [RES_W-1:0] res_op;
        logic             rsp_load;
    } gffra_cmd_t;

    typedef struct packed {
        logic              req_fire;
        logic [TYPE_W-1:0] req_type;
        logic              place_ok;
        logic              fit;
        logic              scan_last;
        logic              fill_last;
        logic              cell_ok;
        logic              sweep_last;
        logic              out_free;
    } gffra_stat_t;

endpackage

// ===== design/gffra_if.sv =====
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on gffra_pkg for field widths.
interface gffra_req_if;
    import gffra_pkg::*;
    logic                valid;
    logic                ready;
    logic [TYPE_W-1:0]   req_type;
    logic [ID_IN_W-1:0]  item_id;
    logic [SIZE_W-1:0]   item_cols;
    logic [SIZE_W-1:0]   item_rows;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;

    modport source (output valid, req_type, item_id, item_cols, item_rows, pos_x, pos_y,
                    input ready);
    modport sink (input valid, req_type, item_id, item_cols, item_rows, pos_x, pos_y,
                  output ready);
endinterface

interface gffra_rsp_if;
    import gffra_pkg::*;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [POS_W-1:0]   slot_x;
    logic [POS_W-1:0]   slot_y;
    logic [ID_IN_W-1:0] found_id;

    modport source (output valid, ok, slot_x, slot_y, found_id, input ready);
    modport sink (input valid, ok, slot_x, slot_y, found_id, output ready);
endinterface

interface gffra_cfg_if;
    import gffra_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// ===== design/gffra_ctrl.sv =====
// Sequencer for the allocator: decodes a request and steps the datapath
// through scan, fill, sweep and result hand-off. Depends on gffra_pkg.
module gffra_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gffra_pkg::gffra_stat_t st,
    output gffra_pkg::gffra_cmd_t  cmd
);
    import gffra_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_PL_SCAN  = 4'd2;
    localparam logic [3:0] S_PL_FILL  = 4'd3;
    localparam logic [3:0] S_RD_DATA  = 4'd4;
    localparam logic [3:0] S_RM_DATA  = 4'd5;
    localparam logic [3:0] S_RM_SWEEP = 4'd6;
    localparam logic [3:0] S_RM_DRAIN = 4'd7;
    localparam logic [3:0] S_RESP     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.req_ready = 1'b1;
                if (st.req_fire)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // cell read for read/remove is issued here
                case (st.req_type)
                    REQ_PLACE:
                    begin
                        if (st.place_ok)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_PL_SCAN;
                        end
                        else
                        begin
                            cmd.res_op = RES_ZERO;
                            state_next = S_RESP;
                        end
                    end
                    REQ_READ:   state_next = S_RD_DATA;
                    REQ_REMOVE: state_next = S_RM_DATA;
                    default:
                    begin
                        cmd.res_op = RES_ZERO;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_PL_SCAN:
            begin
                if (st.fit)
                begin
                    cmd.occ_set    = 1'b1;
                    cmd.res_op     = RES_PLACE;
                    cmd.fill_start = 1'b1;
                    state_next     = S_PL_FILL;
                end
                else if (st.scan_last)
                begin
                    cmd.res_op = RES_ZERO;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_PL_FILL:
            begin
                cmd.fill_run = 1'b1;
                if (st.fill_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RD_DATA:
            begin
                cmd.res_op = RES_READ;
                state_next = S_RESP;
            end
            S_RM_DATA:
            begin
                if (st.cell_ok)
                begin
                    cmd.res_op      = RES_REMOVE;
                    cmd.sweep_start = 1'b1;
                    state_next      = S_RM_SWEEP;
                end
                else
                begin
                    cmd.res_op = RES_ZERO;
                    state_next = S_RESP;
                end
            end
            S_RM_SWEEP:
            begin
                cmd.sweep_sel = 1'b1;
                cmd.sweep_run = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = S_RM_DRAIN;
                end
            end
            S_RM_DRAIN:
            begin
                // last compare of the sweep retires here
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/gffra_dp.sv =====
// Allocator datapath: grid registers, occupancy bits, owner id memory,
// scan/fill/sweep counters, result staging and output register.
// Depends on gffra_pkg and the channel interfaces in gffra_if.sv.
module gffra_dp #(
    parameter int MAX_COLS = gffra_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gffra_pkg::DEF_MAX_ROWS,
    parameter int ID_BITS  = gffra_pkg::DEF_ID_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    gffra_req_if.sink              req,
    gffra_rsp_if.source            rsp,
    gffra_cfg_if.sink              cfg,
    input  gffra_pkg::gffra_cmd_t  cmd,
    output gffra_pkg::gffra_stat_t st
);
    import gffra_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration
    logic [CFG_DATA_W-1:0] cols_reg;
    logic [CFG_DATA_W-1:0] rows_reg;
    logic [SIZE_W-1:0]     act_cols;
    logic [SIZE_W-1:0]     act_rows;

    // captured request
    logic [TYPE_W-1:0]  type_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [SIZE_W-1:0]  w_reg;
    logic [SIZE_W-1:0]  h_reg;
    logic [POS_W-1:0]   px_reg;
    logic [POS_W-1:0]   py_reg;
    logic [23:0]        id_ext;
    logic               req_fire;

    // counters
    logic [SIZE_W-1:0] r_reg;
    logic [SIZE_W-1:0] c_reg;
    logic [SIZE_W-1:0] k_reg;
    logic [SIZE_W-1:0] l_reg;
    logic [SIZE_W-1:0] sr_reg;
    logic [SIZE_W-1:0] sc_reg;
    logic [SIZE_W:0]   r_end;
    logic [SIZE_W:0]   c_end;
    logic [SIZE_W:0]   fr;
    logic [SIZE_W:0]   fc;

    // grid storage
    logic [DEPTH-1:0]   occ_reg;
    logic [ID_BITS-1:0] mem [DEPTH];
    logic [ID_BITS-1:0] rdata_reg;
    logic [MAX_ROWS-1:0] row_in;
    logic [MAX_COLS-1:0] col_in;
    logic [DEPTH-1:0]    rect;
    logic [AW-1:0]       fill_addr;
    logic [AW-1:0]       cell_addr;
    logic [AW-1:0]       sweep_addr;
    logic [AW-1:0]       raddr;
    logic                in_range;
    logic                cell_occ;
    logic                sw_vld_reg;
    logic [AW-1:0]       sw_addr_reg;
    logic [ID_BITS-1:0]  victim_reg;

    // result staging and output
    logic               res_ok_reg;
    logic [POS_W-1:0]   res_x_reg;
    logic [POS_W-1:0]   res_y_reg;
    logic [ID_BITS-1:0] res_fid_reg;
    logic [23:0]        fid_ext;
    logic               rsp_vld_reg;
    logic               rsp_ok_reg;
    logic [POS_W-1:0]   rsp_x_reg;
    logic [POS_W-1:0]   rsp_y_reg;
    logic [ID_IN_W-1:0] rsp_fid_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= GRID_RESET;
            rows_reg <= GRID_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                CFG_COLS: cols_reg <= cfg.data;
                CFG_ROWS: rows_reg <= cfg.data;
                default:  ;
            endcase
        end
    end

    assign act_cols = (int'(cols_reg) > MAX_COLS) ? SIZE_W'(MAX_COLS) : cols_reg;
    assign act_rows = (int'(rows_reg) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : rows_reg;

    // request capture
    assign req.ready = cmd.req_ready;
    assign req_fire  = req.valid && cmd.req_ready;
    assign id_ext    = {16'b0, req.item_id};

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            type_reg <= req.req_type;
            id_reg   <= id_ext[ID_BITS-1:0];
            w_reg    <= req.item_cols;
            h_reg    <= req.item_rows;
            px_reg   <= req.pos_x;
            py_reg   <= req.pos_y;
        end
    end

    // rectangle mask for the current corner
    assign r_end = (SIZE_W+1)'(r_reg) + (SIZE_W+1)'(h_reg);
    assign c_end = (SIZE_W+1)'(c_reg) + (SIZE_W+1)'(w_reg);

    for (genvar i = 0; i < MAX_ROWS; i++)
    begin : g_row
        assign row_in[i] = (7'(i) >= 7'(r_reg)) && (7'(i) < 7'(r_end));
    end

    for (genvar j = 0; j < MAX_COLS; j++)
    begin : g_col
        assign col_in[j] = (7'(j) >= 7'(c_reg)) && (7'(j) < 7'(c_end));
    end

    for (genvar i = 0; i < MAX_ROWS; i++)
    begin : g_mr
        for (genvar j = 0; j < MAX_COLS; j++)
        begin : g_mc
            assign rect[i*MAX_COLS + j] = row_in[i] & col_in[j];
        end
    end

    // corner scan, fill and sweep counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg  <= '0;
            c_reg  <= '0;
            k_reg  <= '0;
            l_reg  <= '0;
            sr_reg <= '0;
            sc_reg <= '0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                r_reg <= '0;
                c_reg <= '0;
            end
            else if (cmd.scan_next)
            begin
                if (c_end < (SIZE_W+1)'(act_cols))
                begin
                    c_reg <= c_reg + 1'b1;
                end
                else
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + 1'b1;
                end
            end

            if (cmd.fill_start)
            begin
                k_reg <= '0;
                l_reg <= '0;
            end
            else if (cmd.fill_run)
            begin
                if ((SIZE_W+1)'(l_reg) + 1'b1 < (SIZE_W+1)'(w_reg))
                begin
                    l_reg <= l_reg + 1'b1;
                end
                else
                begin
                    l_reg <= '0;
                    k_reg <= k_reg + 1'b1;
                end
            end

            if (cmd.sweep_start)
            begin
                sr_reg <= '0;
                sc_reg <= '0;
            end
            else if (cmd.sweep_run)
            begin
                if ((SIZE_W+1)'(sc_reg) + 1'b1 < (SIZE_W+1)'(act_cols))
                begin
                    sc_reg <= sc_reg + 1'b1;
                end
                else
                begin
                    sc_reg <= '0;
                    sr_reg <= sr_reg + 1'b1;
                end
            end
        end
    end

    assign fr        = (SIZE_W+1)'(r_reg) + (SIZE_W+1)'(k_reg);
    assign fc        = (SIZE_W+1)'(c_reg) + (SIZE_W+1)'(l_reg);
    assign fill_addr = AW'(int'(fr) * MAX_COLS + int'(fc));

    assign in_range  = ({1'b0, px_reg} < act_cols) && ({1'b0, py_reg} < act_rows);
    assign cell_addr = in_range ? AW'(int'(py_reg) * MAX_COLS + int'(px_reg)) : '0;
    assign cell_occ  = occ_reg[cell_addr];

    assign sweep_addr = AW'(int'(sr_reg) * MAX_COLS + int'(sc_reg));
    assign raddr      = cmd.sweep_sel ? sweep_addr : cell_addr;

    // owner id memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.fill_run)
        begin
            mem[fill_addr] <= id_reg;
        end
        rdata_reg <= mem[raddr];
    end

    // occupancy bits: set a whole rectangle, clear one swept cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= '0;
            sw_vld_reg  <= 1'b0;
            sw_addr_reg <= '0;
        end
        else
        begin
            sw_vld_reg  <= cmd.sweep_run;
            sw_addr_reg <= sweep_addr;
            if (cmd.occ_set)
            begin
                occ_reg <= occ_reg | rect;
            end
            else if (sw_vld_reg && (rdata_reg == victim_reg))
            begin
                occ_reg[sw_addr_reg] <= 1'b0;
            end
        end
    end

    // result staging
    always_ff @(posedge clk)
    begin
        case (cmd.res_op)
            RES_ZERO:
            begin
                res_ok_reg  <= 1'b0;
                res_x_reg   <= '0;
                res_y_reg   <= '0;
                res_fid_reg <= '0;
            end
            RES_PLACE:
            begin
                res_ok_reg  <= 1'b1;
                res_x_reg   <= c_reg[POS_W-1:0];
                res_y_reg   <= r_reg[POS_W-1:0];
                res_fid_reg <= '0;
            end
            RES_READ:
            begin
                res_ok_reg  <= in_range;
                res_x_reg   <= '0;
                res_y_reg   <= '0;
                res_fid_reg <= (in_range && cell_occ) ? rdata_reg : '0;
            end
            RES_REMOVE:
            begin
                res_ok_reg  <= 1'b1;
                res_x_reg   <= '0;
                res_y_reg   <= '0;
                res_fid_reg <= rdata_reg;
                victim_reg  <= rdata_reg;
            end
            default: ;
        endcase
    end

    // output register
    assign fid_ext = 24'(res_fid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (cmd.rsp_load)
        begin
            rsp_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
        begin
            rsp_ok_reg  <= res_ok_reg;
            rsp_x_reg   <= res_x_reg;
            rsp_y_reg   <= res_y_reg;
            rsp_fid_reg <= fid_ext[ID_IN_W-1:0];
        end
    end

    assign rsp.valid    = rsp_vld_reg;
    assign rsp.ok       = rsp_ok_reg;
    assign rsp.slot_x   = rsp_x_reg;
    assign rsp.slot_y   = rsp_y_reg;
    assign rsp.found_id = rsp_fid_reg;

    // status to the sequencer
    assign st.req_fire   = req_fire;
    assign st.req_type   = type_reg;
    assign st.place_ok   = (id_reg != '0) && (w_reg != '0) && (h_reg != '0)
                           && (w_reg <= act_cols) && (h_reg <= act_rows);
    assign st.fit        = ~|(occ_reg & rect);
    assign st.scan_last  = (r_end >= (SIZE_W+1)'(act_rows))
                           && (c_end >= (SIZE_W+1)'(act_cols));
    assign st.fill_last  = ((SIZE_W+1)'(l_reg) + 1'b1 >= (SIZE_W+1)'(w_reg))
                           && ((SIZE_W+1)'(k_reg) + 1'b1 >= (SIZE_W+1)'(h_reg));
    assign st.cell_ok    = in_range && cell_occ;
    assign st.sweep_last = ((SIZE_W+1)'(sc_reg) + 1'b1 >= (SIZE_W+1)'(act_cols))
                           && ((SIZE_W+1)'(sr_reg) + 1'b1 >= (SIZE_W+1)'(act_rows));
    assign st.out_free   = !rsp_vld_reg || rsp.ready;

endmodule

// ===== design/grid_first_fit_rect_allocator_top.sv =====
// Top level of the grid first-fit rectangle allocator.
// Depends on gffra_pkg, gffra_if.sv, gffra_ctrl and gffra_dp.
//
// Channels: req (valid/ready) carries one request transaction: place a
// rectangle, read a cell, or remove the item covering a cell. rsp returns
// exactly one result transaction per request, in order. cfg writes the
// active grid width (index 0) and height (index 1); it is always ready and
// must only be written while no request is in flight.
//
// Steps after a request is accepted, up to the load of the output register:
//   read:   decode with the cell read issued, then the read data is staged.
//   place:  decode, the corner scan, then the fill of the rectangle;
//           the corner scan tests one corner per cycle against all occupancy
//           bits at once, and the fill writes one cell per cycle through the
//           single write port of the owner memory.
//   remove: decode with the cell read, the victim is staged, then every active
//           cell is swept and the last compare drains; the owner memory is
//           swept one cell per cycle to clear every cell of the victim.
// The next request is accepted the cycle after the result is loaded, so a
// result may wait in the output register while the next request is worked.
// Reset clears all occupancy bits at once (owner memory needs no clearing),
// sets the grid to 10 x 10 and empties the output register. If the receiver
// stalls, hold the result and stop at the hand-off of the next result.
module grid_first_fit_rect_allocator_top #(
    parameter int MAX_COLS = gffra_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gffra_pkg::DEF_MAX_ROWS,
    parameter int ID_BITS  = gffra_pkg::DEF_ID_BITS
) (
    input logic         clk,
    input logic         rst_n,
    gffra_req_if.sink   req,
    gffra_rsp_if.source rsp,
    gffra_cfg_if.sink   cfg
);
    import gffra_pkg::*;

    gffra_cmd_t  cmd;
    gffra_stat_t st;

    // sequencer: one request at a time
    gffra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // grid storage, counters and channel registers
    gffra_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .ID_BITS  (ID_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .st    (st)
    );

    // Never overwrite a result that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_load |-> st.out_free)
        else $error("result loaded while output register still occupied");

    // Stop taking requests once one is in flight.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in flight");

    // Grid updates only happen while a request is being worked.
    a_no_update_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.req_ready |-> !(cmd.fill_run || cmd.sweep_run || cmd.occ_set))
        else $error("grid update while idle");

    // Mark a rectangle occupied only where it was found free.
    a_set_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.occ_set |-> st.fit)
        else $error("rectangle claimed over occupied cells");

endmodule
